>>> rtl/core/adpcm_pkg.sv
// Shared constants, command types and helpers for the DSP ADPCM decoder core.
// Used by adpcm_front, adpcm_queue, adpcm_back and dsp_adpcm_decoder_core.
// No dependencies.
package adpcm_pkg;

  // Channels held on chip (coefficient tables, history, sample counts).
  localparam int CHANNELS = 2;
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

  // Coefficients are kept as two banks: even slots (c1) and odd slots (c2).
  localparam int COEF_DEPTH = CHANNELS * 8;
  localparam int COEF_AW = $clog2(COEF_DEPTH);

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW = $clog2(QUEUE_DEPTH);

  // Stream word widths.
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 24;

  // Frame layout and fixed-point scaling.
  localparam int FRAME_BYTES = 8;
  localparam logic [2:0] LAST_POS = 3'(FRAME_BYTES - 1);
  localparam int FRAC_BITS = 11;
  localparam int ROUND_HALF = 1024;
  localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;
  localparam logic signed [15:0] PCM_MIN = -16'sh8000;

  // Input op codes.
  localparam logic [1:0] OP_COEF = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DATA = 2'd2;

  typedef logic [CH_W-1:0] chan_t;

  typedef enum logic [1:0] {
    CMD_COEF  = 2'd0,
    CMD_START = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_kind_t;

  // One queued command. Loads use slot/v0/v1/count, data bytes use pred/shift/data.
  typedef struct packed {
    cmd_kind_t   kind;
    chan_t       ch;
    logic [3:0]  slot;
    logic [15:0] v0;
    logic [15:0] v1;
    logic [31:0] count;
    logic [2:0]  pred;
    logic [3:0]  shift;
    logic [7:0]  data;
  } cmd_t;

  function automatic logic [COEF_AW-1:0] coef_addr(chan_t ch, logic [2:0] pair);
    logic [CH_W+2:0] full;
    full = {ch, pair};
    return full[COEF_AW-1:0];
  endfunction

endpackage

>>> rtl/core/adpcm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adpcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/adpcm_front.sv
// Front end: takes input words, tracks frame position and channel, turns
// loads and data bytes into queued commands. Depends on adpcm_pkg.
module adpcm_front import adpcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [3:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic [1:0]           in_op,
  input  logic                 q_full,
  output logic                 push,
  output cmd_t                 cmd
);

  logic [3:0] chan_count;
  logic [2:0] byte_pos;
  chan_t      cur_ch;
  logic [2:0] frame_pred;
  logic [3:0] frame_shift;

  logic        accept;
  logic [2:0]  f_channel;
  logic [3:0]  f_coef_index;
  logic [15:0] f_coef_value;
  logic [15:0] f_start_first;
  logic [15:0] f_start_second;
  logic [31:0] f_emit_count;
  logic [7:0]  f_data_byte;
  logic        chan_ok;
  logic [3:0]  active;
  logic [3:0]  ch_step;

  assign f_channel      = in_data[2:0];
  assign f_coef_index   = in_data[6:3];
  assign f_coef_value   = in_data[22:7];
  assign f_start_first  = in_data[38:23];
  assign f_start_second = in_data[54:39];
  assign f_emit_count   = in_data[86:55];
  assign f_data_byte    = in_data[94:87];

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign chan_ok  = 4'(f_channel) < CH_LIMIT;
  assign ch_step  = 4'(cur_ch) + 4'd1;

  always_comb begin
    priority if (chan_count == 4'd0) begin
      active = 4'd1;
    end else if (chan_count > CH_LIMIT) begin
      active = CH_LIMIT;
    end else begin
      active = chan_count;
    end
  end

  always_comb begin
    cmd.kind  = CMD_DATA;
    cmd.ch    = cur_ch;
    cmd.slot  = f_coef_index;
    cmd.v0    = (in_op == OP_COEF) ? f_coef_value : f_start_first;
    cmd.v1    = f_start_second;
    cmd.count = f_emit_count;
    cmd.pred  = frame_pred;
    cmd.shift = frame_shift;
    cmd.data  = f_data_byte;
    push      = 1'b0;
    unique case (in_op)
      OP_COEF: begin
        cmd.kind = CMD_COEF;
        cmd.ch   = f_channel[CH_W-1:0];
        push     = accept && chan_ok;
      end
      OP_START: begin
        cmd.kind = CMD_START;
        cmd.ch   = f_channel[CH_W-1:0];
        push     = accept && chan_ok;
      end
      OP_DATA: begin
        // header byte stays here, data bytes go to the back end
        push = accept && (byte_pos != 3'd0);
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_count  <= 4'd1;
      byte_pos    <= 3'd0;
      cur_ch      <= '0;
      frame_pred  <= 3'd0;
      frame_shift <= 4'd0;
    end else begin
      if (cfg_valid) begin
        chan_count <= cfg_data;
      end
      if (accept && in_op == OP_DATA) begin
        if (byte_pos == 3'd0) begin
          frame_pred  <= f_data_byte[6:4];
          frame_shift <= f_data_byte[3:0];
        end
        if (byte_pos == LAST_POS) begin
          byte_pos <= 3'd0;
          cur_ch   <= (ch_step >= active) ? '0 : ch_step[CH_W-1:0];
        end else begin
          byte_pos <= byte_pos + 3'd1;
        end
      end
    end
  end

endmodule

>>> rtl/core/adpcm_queue.sv
// Short command queue between the front end and the back end.
// Depends on adpcm_pkg.
module adpcm_queue import adpcm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  cmd_t           entries [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   fill;

  assign full  = fill == (QAW+1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> rtl/core/adpcm_back.sv
// Back end: executes queued commands, holds coefficients, history and sample
// counts, runs the two dependent predictions of a byte and drives the output
// register. Depends on adpcm_pkg and adpcm_ram.
module adpcm_back import adpcm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head,
  input  logic        q_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_sample,
  output logic [2:0]  out_chan,
  output logic        out_last
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_MUL0 = 5'b00010,
    B_ADD0 = 5'b00100,
    B_MUL1 = 5'b01000,
    B_ADD1 = 5'b10000
  } back_state_t;

  back_state_t state;
  back_state_t state_next;

  logic signed [15:0] hist_first  [CHANNELS];
  logic signed [15:0] hist_second [CHANNELS];
  logic [31:0]        samples_left [CHANNELS];

  chan_t              act_ch;
  logic [7:0]         act_data;
  logic [3:0]         act_shift;
  logic               act_emit1;
  logic signed [15:0] c1_r;
  logic signed [15:0] c2_r;
  logic signed [31:0] p1;
  logic signed [31:0] p2;
  logic signed [30:0] term_r;

  logic [15:0]        rd_even;
  logic [15:0]        rd_odd;
  logic               we_even;
  logic               we_odd;
  logic [COEF_AW-1:0] waddr;
  logic [COEF_AW-1:0] raddr;

  logic               out_free;
  logic               advance;
  logic               head_live;
  logic [3:0]         nib;
  logic signed [19:0] nib_sh;
  logic signed [30:0] term;
  logic signed [15:0] c1;
  logic signed [15:0] c2;
  logic signed [33:0] sum;
  logic signed [22:0] quot;
  logic signed [15:0] sat;

  assign pop       = (state == B_IDLE) && !q_empty;
  assign head_live = samples_left[head.ch] != 32'd0;
  assign out_free  = !out_valid || out_ready;
  assign advance   = out_free;

  assign waddr   = coef_addr(head.ch, head.slot[3:1]);
  assign raddr   = coef_addr(head.ch, head.pred);
  assign we_even = pop && head.kind == CMD_COEF && !head.slot[0];
  assign we_odd  = pop && head.kind == CMD_COEF && head.slot[0];

  adpcm_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata (head.v0),
    .raddr (raddr),
    .rdata (rd_even)
  );

  adpcm_ram #(.WIDTH(16), .DEPTH(COEF_DEPTH)) u_coef_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata (head.v0),
    .raddr (raddr),
    .rdata (rd_odd)
  );

  // Multiply stage operands: fresh RAM data on the first sample, held copy after.
  always_comb begin
    nib    = (state == B_MUL0) ? act_data[7:4] : act_data[3:0];
    c1     = (state == B_MUL0) ? $signed(rd_even) : c1_r;
    c2     = (state == B_MUL0) ? $signed(rd_odd) : c2_r;
    nib_sh = $signed({{16{nib[3]}}, nib}) <<< act_shift;
    term   = $signed({nib_sh, 11'b0}) + 31'(ROUND_HALF);
  end

  // Add stage: floor divide by 2048, then clamp to 16 bits.
  always_comb begin
    sum  = 34'(term_r) + 34'(p1) + 34'(p2);
    quot = sum[33:FRAC_BITS];
    priority if (quot > 23'(PCM_MAX)) begin
      sat = PCM_MAX;
    end else if (quot < 23'(PCM_MIN)) begin
      sat = PCM_MIN;
    end else begin
      sat = quot[15:0];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (pop && head.kind == CMD_DATA && head_live) begin
          state_next = B_MUL0;
        end
      end
      B_MUL0: state_next = B_ADD0;
      B_ADD0: begin
        if (advance) begin
          state_next = act_emit1 ? B_MUL1 : B_IDLE;
        end
      end
      B_MUL1: state_next = B_ADD1;
      B_ADD1: begin
        if (advance) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        hist_first[i]   <= '0;
        hist_second[i]  <= '0;
        samples_left[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (pop && head.kind == CMD_START) begin
        hist_first[head.ch]   <= $signed(head.v0);
        hist_second[head.ch]  <= $signed(head.v1);
        samples_left[head.ch] <= head.count;
      end
      if ((state == B_ADD0 || state == B_ADD1) && advance) begin
        hist_second[act_ch]  <= hist_first[act_ch];
        hist_first[act_ch]   <= sat;
        samples_left[act_ch] <= samples_left[act_ch] - 32'd1;
        out_valid            <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      act_ch    <= head.ch;
      act_data  <= head.data;
      act_shift <= head.shift;
      act_emit1 <= samples_left[head.ch][31:1] != 31'd0;
    end
    if (state == B_MUL0) begin
      c1_r <= c1;
      c2_r <= c2;
    end
    if (state == B_MUL0 || state == B_MUL1) begin
      p1     <= c1 * hist_first[act_ch];
      p2     <= c2 * hist_second[act_ch];
      term_r <= term;
    end
    if ((state == B_ADD0 || state == B_ADD1) && advance) begin
      out_sample <= sat;
      out_chan   <= 3'(act_ch);
      out_last   <= (state == B_ADD1) || !act_emit1;
    end
  end

endmodule

>>> rtl/core/dsp_adpcm_decoder_core.sv
// Top level of the DSP ADPCM decoder core: front end, command queue, back end.
// Depends on adpcm_pkg, adpcm_front, adpcm_queue, adpcm_back (and adpcm_ram).
//
//  Channel   Dir  Handshake              Payload
//  cfg       in   cfg_valid/cfg_ready    cfg_data = channel_count
//  s_axis    in   s_axis_tvalid/tready   tdata = load/data fields, tuser = op
//  m_axis    out  m_axis_tvalid/tready   tdata = sample, channel; tlast = last
//
// The front end takes one input word per cycle while the command queue has room;
// header bytes, out-of-range loads and unused ops never reach the queue.
// The back end takes loads and data bytes with no sample left from the queue
// while idle; a data byte runs one prediction per sample left, at most two, each
// a multiply state then an add/clamp state, and the second prediction waits for
// the first (history feedback).
// Reset clears history, sample counts and frame position; coefficients are
// undefined until loaded. A stalled output holds the back end; the queue then
// fills up to four commands and s_axis_tready drops until the output moves.
module dsp_adpcm_decoder_core import adpcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // channel_count register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data,
  // input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [2:0] channel, [6:3] coef_index, [22:7] coef_value, [38:23] start_first,
  // [54:39] start_second, [86:55] emit_count, [94:87] data_byte, [95] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] op
  input  logic [1:0]            s_axis_tuser,
  // output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] pcm_sample, [18:16] sample_channel, [23:19] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic        q_push;
  cmd_t        q_in;
  logic        q_pop;
  cmd_t        q_head;
  logic        q_full;
  logic        q_empty;
  logic [15:0] pcm;
  logic [2:0]  pcm_chan;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  adpcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .in_op     (s_axis_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .cmd       (q_in)
  );

  adpcm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  adpcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_sample (pcm),
    .out_chan   (pcm_chan),
    .out_last   (m_axis_tlast)
  );

  // pack the output word, pad to whole bytes
  assign m_axis_tdata = {5'd0, pcm_chan, pcm};

endmodule
